// ----- sv/pclkdiv_pkg.sv -----
// Shared widths, constants and transaction types for the pixel clock divider search.
// Used by pclkdiv_cand, pclkdiv_cell and pixel_clock_divider_search_top; no dependencies.

package pclkdiv_pkg;

    // Default divider span.
    localparam int M_FIRST_DEF = 5;
    localparam int M_LAST_DEF  = 96;

    // Field widths.
    localparam int TGT_W = 29;
    localparam int M_W   = 8;
    localparam int DM_W  = 7;
    localparam int N_W   = 7;
    localparam int ERR_W = 28;

    // Internal widths.
    localparam int X_W   = TGT_W + M_W;   // m * target
    localparam int XL_W  = 30;            // m * target below the limit
    localparam int Q_W   = 8;             // quotient by the 3 MHz step
    localparam int R_W   = 22;            // remainder by the 3 MHz step
    localparam int Y_W   = 23;            // rounded-up remainder before dividing by m
    localparam int QP_W  = 41;            // reciprocal product for the step quotient
    localparam int RC_W  = 25;            // reciprocal of m
    localparam int EP_W  = 48;            // reciprocal product for the error
    localparam int RM_W  = 31;            // correction remainder

    // Arithmetic constants.
    localparam int unsigned STEP      = 3000000;
    localparam int unsigned X_LIMIT   = 768000000;   // 256 steps: no n can fit above this
    localparam int unsigned QR_MUL    = 1431;        // floor(2^32 / 3000000)
    localparam int          QR_SHIFT  = 32;
    localparam int          ERR_SHIFT = 24;
    localparam int unsigned N_LOW     = 9;
    localparam int unsigned N_HIGH    = 127;
    localparam logic [ERR_W-1:0] NO_FIT_ERR = 28'h0FFFFFFF;

    // Register stages inside one candidate unit.
    localparam int CAND_LAT = 5;

    typedef struct packed {
        logic             s_ok;
        logic [N_W-1:0]   s_n;
        logic [Y_W-1:0]   s_err;
        logic             d_ok;
        logic [N_W-1:0]   d_n;
        logic [Y_W-1:0]   d_err;
    } t_cand;

    typedef struct packed {
        logic             found;
        logic [DM_W-1:0]  m;
        logic [N_W-1:0]   n;
        logic             dbl;
        logic [ERR_W-1:0] err;
    } t_best;

endpackage

// ----- sv/pixel_clock_divider_search_top.sv -----
// Top level of the pixel clock divider search: a chain of divider cells and an output
// register. Depends on pclkdiv_pkg and pclkdiv_cell.
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+--------------------------------------------
//   request | in        | i_valid / o_stall | i_target_hz
//   result  | out       | o_valid / i_stall | o_found, o_divider_m, o_multiplier_n,
//           |           |                   | o_doubled, o_error_hz
//
// One transaction is taken every cycle while o_stall is low. Each divider cell holds a five-stage
// candidate unit and a merge stage, and the output register follows the last cell.
// Reset clears only the valid bits; payload registers are left as they are.
// The whole chain advances together; it halts only while the output register holds a result
// and i_stall is high, and o_stall follows that condition.

module pixel_clock_divider_search_top #(
    parameter int M_FIRST = pclkdiv_pkg::M_FIRST_DEF,
    parameter int M_LAST  = pclkdiv_pkg::M_LAST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pclkdiv_pkg::TGT_W-1:0]   i_target_hz,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [pclkdiv_pkg::DM_W-1:0]    o_divider_m,
    output logic [pclkdiv_pkg::N_W-1:0]     o_multiplier_n,
    output logic                            o_doubled,
    output logic [pclkdiv_pkg::ERR_W-1:0]   o_error_hz
);
    import pclkdiv_pkg::*;

    localparam int N_CELL = (M_LAST >= M_FIRST) ? (M_LAST - M_FIRST + 1) : 0;

    logic             chain_v   [N_CELL+1];
    logic [TGT_W-1:0] chain_tgt [N_CELL+1];
    t_best            chain_best[N_CELL+1];
    t_best            best_init;
    logic             en;
    logic             r_out_valid;
    t_best            r_out;

    always_comb begin
        best_init.found = 1'b0;
        best_init.m     = '0;
        best_init.n     = '0;
        best_init.dbl   = 1'b0;
        best_init.err   = NO_FIT_ERR;
    end

    assign en = !(r_out_valid && i_stall);

    assign chain_v[0]    = i_valid;
    assign chain_tgt[0]  = i_target_hz;
    assign chain_best[0] = best_init;

    for (genvar g = 0; g < N_CELL; g++) begin : g_cell
        pclkdiv_cell #(
            .M_VAL (M_FIRST + g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (chain_v[g]),
            .i_target (chain_tgt[g]),
            .i_best   (chain_best[g]),
            .o_valid  (chain_v[g+1]),
            .o_target (chain_tgt[g+1]),
            .o_best   (chain_best[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain_v[N_CELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= chain_best[N_CELL];
        end
    end

    assign o_stall        = !en;
    assign o_valid        = r_out_valid;
    assign o_found        = r_out.found;
    assign o_divider_m    = r_out.m;
    assign o_multiplier_n = r_out.n;
    assign o_doubled      = r_out.dbl;
    assign o_error_hz     = r_out.err;

endmodule

// ----- sv/pclkdiv_cand.sv -----
// Five-stage candidate unit for one fixed divider m: forms n for single and doubled
// mode and the resulting error. Depends on pclkdiv_pkg.

module pclkdiv_cand #(
    parameter int M_VAL = pclkdiv_pkg::M_FIRST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [pclkdiv_pkg::TGT_W-1:0]   i_target,
    output pclkdiv_pkg::t_cand              o_cand
);
    import pclkdiv_pkg::*;

    localparam logic [M_W-1:0]  M8    = M_W'(M_VAL);
    localparam int              M_DIV = (M_VAL == 0) ? 1 : M_VAL;
    localparam logic [RC_W-1:0] RECIP = RC_W'((1 << ERR_SHIFT) / M_DIV);
    localparam logic [Y_W-1:0]  M_ADJ = Y_W'(M_DIV - 1);
    localparam logic            M_NZ  = (M_VAL != 0);

    // Stage 1
    logic [X_W-1:0]  r_x;
    // Stage 2
    logic            r_big2;
    logic [XL_W-1:0] r_xl;
    logic [Q_W-1:0]  r_qe;
    // Stage 3
    logic            r_big3;
    logic [Q_W-1:0]  r_q;
    logic [R_W-1:0]  r_r;
    // Stage 4
    logic            r_ok_s;
    logic            r_ok_d;
    logic [N_W-1:0]  r_n_s;
    logic [N_W-1:0]  r_n_d;
    logic [Y_W-1:0]  r_y_s;
    logic [Y_W-1:0]  r_y_d;
    logic [Y_W-1:0]  r_e_s;
    logic [Y_W-1:0]  r_e_d;
    // Stage 5
    t_cand           r_cand;

    logic [QP_W-1:0] q_prod;
    logic [XL_W-1:0] rem0;
    logic            q_fix;
    logic [Y_W-1:0]  y_s;
    logic [Y_W-1:0]  y_d;
    logic [EP_W-1:0] p_s;
    logic [EP_W-1:0] p_d;
    logic [N_W-1:0]  n_half;
    logic [RM_W-1:0] rem_s;
    logic [RM_W-1:0] rem_d;

    always_comb begin
        q_prod = QP_W'(r_x[XL_W-1:0]) * QP_W'(QR_MUL);
        rem0   = r_xl - XL_W'(r_qe) * XL_W'(STEP);
        q_fix  = (rem0 >= XL_W'(STEP));
        // The error is ceil(remainder / m), so round up before dividing.
        y_s    = Y_W'(r_r) + M_ADJ;
        y_d    = Y_W'(r_r) + (r_q[0] ? Y_W'(STEP) : '0) + M_ADJ;
        p_s    = EP_W'(y_s) * EP_W'(RECIP);
        p_d    = EP_W'(y_d) * EP_W'(RECIP);
        n_half = r_q[Q_W-1:1];
        rem_s  = RM_W'(r_y_s) - RM_W'(r_e_s) * RM_W'(M8);
        rem_d  = RM_W'(r_y_d) - RM_W'(r_e_d) * RM_W'(M8);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= X_W'(M8) * X_W'(i_target);

            r_big2 <= (r_x >= X_W'(X_LIMIT));
            r_xl   <= r_x[XL_W-1:0];
            r_qe   <= q_prod[QR_SHIFT +: Q_W];

            // The reciprocal estimate is at most one short of the true quotient.
            r_big3 <= r_big2;
            r_q    <= q_fix ? r_qe + Q_W'(1) : r_qe;
            r_r    <= q_fix ? R_W'(rem0 - XL_W'(STEP)) : R_W'(rem0);

            r_ok_s <= M_NZ && !r_big3 && (r_q >= Q_W'(N_LOW)) && (r_q <= Q_W'(N_HIGH));
            // Halving an 8-bit quotient cannot exceed the upper bound of n.
            r_ok_d <= M_NZ && M8[0] && !r_big3 && (n_half >= N_W'(N_LOW));
            r_n_s  <= r_q[N_W-1:0];
            r_n_d  <= n_half;
            r_y_s  <= y_s;
            r_y_d  <= y_d;
            r_e_s  <= p_s[ERR_SHIFT +: Y_W];
            r_e_d  <= p_d[ERR_SHIFT +: Y_W];

            r_cand.s_ok  <= r_ok_s;
            r_cand.s_n   <= r_n_s;
            r_cand.s_err <= (rem_s >= RM_W'(M8)) ? r_e_s + Y_W'(1) : r_e_s;
            r_cand.d_ok  <= r_ok_d;
            r_cand.d_n   <= r_n_d;
            r_cand.d_err <= (rem_d >= RM_W'(M8)) ? r_e_d + Y_W'(1) : r_e_d;
        end
    end

    assign o_cand = r_cand;

endmodule

// ----- sv/pclkdiv_cell.sv -----
// One divider cell of the search chain: a candidate unit for its m, delay lines for the
// transaction travelling alongside, and a merge stage keeping the best pair. Uses pclkdiv_pkg.

module pclkdiv_cell #(
    parameter int M_VAL = pclkdiv_pkg::M_FIRST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [pclkdiv_pkg::TGT_W-1:0]   i_target,
    input  pclkdiv_pkg::t_best              i_best,
    output logic                            o_valid,
    output logic [pclkdiv_pkg::TGT_W-1:0]   o_target,
    output pclkdiv_pkg::t_best              o_best
);
    import pclkdiv_pkg::*;

    localparam logic [M_W-1:0] M8 = M_W'(M_VAL);

    logic [CAND_LAT-1:0] r_v_d;
    logic [TGT_W-1:0]    r_tgt_d [CAND_LAT];
    t_best               r_best_d [CAND_LAT];
    logic                r_v_o;
    logic [TGT_W-1:0]    r_tgt_o;
    t_best               r_best_o;
    t_cand               cand;
    t_best               merged;

    pclkdiv_cand #(
        .M_VAL (M_VAL)
    ) u_cand (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_target (i_target),
        .o_cand   (cand)
    );

    // Strictly smaller wins, so ties keep the earlier divider and single mode.
    always_comb begin
        merged = r_best_d[CAND_LAT-1];
        if (cand.s_ok && (ERR_W'(cand.s_err) < merged.err)) begin
            merged.found = 1'b1;
            merged.m     = M8[DM_W-1:0];
            merged.n     = cand.s_n;
            merged.dbl   = 1'b0;
            merged.err   = ERR_W'(cand.s_err);
        end
        if (cand.d_ok && (ERR_W'(cand.d_err) < merged.err)) begin
            merged.found = 1'b1;
            merged.m     = M8[DM_W-1:0];
            merged.n     = cand.d_n;
            merged.dbl   = 1'b1;
            merged.err   = ERR_W'(cand.d_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_d <= '0;
            r_v_o <= 1'b0;
        end else if (i_en) begin
            r_v_d <= {r_v_d[CAND_LAT-2:0], i_valid};
            r_v_o <= r_v_d[CAND_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tgt_d[0]  <= i_target;
            r_best_d[0] <= i_best;
            for (int k = 1; k < CAND_LAT; k++) begin
                r_tgt_d[k]  <= r_tgt_d[k-1];
                r_best_d[k] <= r_best_d[k-1];
            end
            r_tgt_o  <= r_tgt_d[CAND_LAT-1];
            r_best_o <= merged;
        end
    end

    assign o_valid  = r_v_o;
    assign o_target = r_tgt_o;
    assign o_best   = r_best_o;

endmodule

// ----- test/pixel_clock_divider_search_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the pixel clock divider search: watches both channels, predicts each result
// and compares it field by field. Depends on pclkdiv_pkg for the result type and constants.

module pixel_clock_divider_search_checker #(
    parameter int M_FIRST = pclkdiv_pkg::M_FIRST_DEF,
    parameter int M_LAST  = pclkdiv_pkg::M_LAST_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic [pclkdiv_pkg::TGT_W-1:0]   i_target_hz,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic                            i_found,
    input  logic [pclkdiv_pkg::DM_W-1:0]    i_divider_m,
    input  logic [pclkdiv_pkg::N_W-1:0]     i_multiplier_n,
    input  logic                            i_doubled,
    input  logic [pclkdiv_pkg::ERR_W-1:0]   i_error_hz,
    output int                              o_outstanding,
    output int                              o_failures
);
    import pclkdiv_pkg::*;

    localparam longint unsigned STEP_SINGLE = STEP;
    localparam longint unsigned STEP_DOUBLE = 2 * STEP;

    t_best expected_q[$];
    int    fail_cnt = 0;

    // Best divider pair for one target. Single mode is tried before doubled for each m,
    // and only a strictly smaller error replaces the current best, which gives the tie order.
    function automatic t_best best_divider_pair(input logic [TGT_W-1:0] target);
        longint unsigned tgt;
        longint unsigned step;
        longint unsigned n;
        longint unsigned err;
        longint unsigned best_err;
        longint unsigned best_m;
        longint unsigned best_n;
        bit              best_dbl;
        bit              have;
        t_best           res;
        tgt      = target;
        best_err = NO_FIT_ERR;
        best_m   = 0;
        best_n   = 0;
        best_dbl = 1'b0;
        have     = 1'b0;
        for (int m = M_FIRST; m <= M_LAST; m++) begin
            if (m == 0) continue;
            for (int pass = 0; pass < 2; pass++) begin
                if (pass == 1 && (m % 2) == 0) continue;
                step = (pass == 1) ? STEP_DOUBLE : STEP_SINGLE;
                n = (longint'(m) * tgt) / step;
                if (n < N_LOW || n > N_HIGH) continue;
                err = tgt - (step * n) / longint'(m);
                if (err < best_err) begin
                    have     = 1'b1;
                    best_err = err;
                    best_m   = m;
                    best_n   = n;
                    best_dbl = (pass == 1);
                end
            end
        end
        if (!have) begin
            best_err = NO_FIT_ERR;
            best_m   = 0;
            best_n   = 0;
            best_dbl = 1'b0;
        end
        res.found = have;
        res.m     = best_m[DM_W-1:0];
        res.n     = best_n[N_W-1:0];
        res.dbl   = best_dbl;
        res.err   = best_err[ERR_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_best exp_res;
        if (!i_rst_n) begin
            expected_q.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_q.push_back(best_divider_pair(i_target_hz));
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_cnt++;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_found !== exp_res.found) begin
                        $error("found: expected %0d, got %0d", exp_res.found, i_found);
                        fail_cnt++;
                    end
                    if (i_divider_m !== exp_res.m) begin
                        $error("divider_m: expected %0d, got %0d", exp_res.m, i_divider_m);
                        fail_cnt++;
                    end
                    if (i_multiplier_n !== exp_res.n) begin
                        $error("multiplier_n: expected %0d, got %0d", exp_res.n,
                               i_multiplier_n);
                        fail_cnt++;
                    end
                    if (i_doubled !== exp_res.dbl) begin
                        $error("doubled: expected %0d, got %0d", exp_res.dbl, i_doubled);
                        fail_cnt++;
                    end
                    if (i_error_hz !== exp_res.err) begin
                        $error("error_hz: expected %0d, got %0d", exp_res.err, i_error_hz);
                        fail_cnt++;
                    end
                end
            end
        end
        o_outstanding <= expected_q.size();
        o_failures    <= fail_cnt;
    end

endmodule

// ----- test/pixel_clock_divider_search_top_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the pixel clock divider search: clock, reset, request stimulus and
// receiver stalls. Depends on pclkdiv_pkg, the block and pixel_clock_divider_search_checker.

module pixel_clock_divider_search_top_test;
    import pclkdiv_pkg::*;

    localparam int LATENCY     = 6 * (M_LAST_DEF - M_FIRST_DEF + 1) + 1;
    localparam int PHASE_ITEMS = 266;
    // Targets between these bounds can reach some divider pair.
    localparam int unsigned FIT_LOW  = 281250;
    localparam int unsigned FIT_HIGH = 153600000;
    localparam int unsigned TGT_HIGH = 300000000;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic [TGT_W-1:0]   i_target_hz    = '0;
    logic               i_stall        = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_found;
    logic [DM_W-1:0]    o_divider_m;
    logic [N_W-1:0]     o_multiplier_n;
    logic               o_doubled;
    logic [ERR_W-1:0]   o_error_hz;
    int                 outstanding;
    int                 failures;
    int                 tx_idle_pct    = 0;
    int                 rx_stall_pct   = 0;

    pixel_clock_divider_search_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_target_hz    (i_target_hz),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_divider_m    (o_divider_m),
        .o_multiplier_n (o_multiplier_n),
        .o_doubled      (o_doubled),
        .o_error_hz     (o_error_hz)
    );

    pixel_clock_divider_search_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_target_hz    (i_target_hz),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_found        (o_found),
        .i_divider_m    (o_divider_m),
        .i_multiplier_n (o_multiplier_n),
        .i_doubled      (o_doubled),
        .i_error_hz     (o_error_hz),
        .o_outstanding  (outstanding),
        .o_failures     (failures)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Offers one request, idling first at the current rate, and returns once it is taken.
    // Valid is left high so that a following request can go out on the next cycle.
    task automatic send_target(input logic [TGT_W-1:0] target);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_target_hz <= target;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mostly targets that can fit, with some below and above the usable band and some
    // across the whole field width.
    function automatic logic [TGT_W-1:0] random_target();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return TGT_W'($urandom_range(FIT_HIGH, FIT_LOW));
        if (sel < 80) return TGT_W'($urandom_range(FIT_LOW + 1000, 0));
        if (sel < 90) return TGT_W'($urandom_range(TGT_HIGH, FIT_HIGH - 1000));
        return TGT_W'($urandom);
    endfunction

    initial begin
        int unsigned directed[$];
        directed = '{
            0, 1, FIT_LOW - 1, FIT_LOW, 3000000, 6000000, 25175000, 27000000,
            65000000, 74250000, 76199999, 76200000, 108000000, 148500000,
            152400000, FIT_HIGH - 1, FIT_HIGH, TGT_HIGH, 32'h0FFFFFFF,
            32'h10000000, 32'h1FFFFFFF, 32'h0AAAAAAA, 32'h15555555
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_target(TGT_W'(directed[k]));
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 21;
                    rx_stall_pct = 60;
                end
                1: begin
                    tx_idle_pct  = 60;
                    rx_stall_pct = 21;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) send_target(random_target());
            // Hold requests back until the pipeline has emptied once.
            if (phase == 0) drain_results();
        end

        drain_results();
        repeat (LATENCY + 50) @(posedge i_clk);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
